// ===== hw/rtl/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ATS shaper package
// Widths, register indexes and shared helpers for the eligibility time shaper.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    localparam int TIME_W     = 64;
    localparam int RATE_W     = 37;
    localparam int BURST_W    = 32;
    localparam int OH_W       = 8;
    localparam int PD_W       = 32;
    localparam int LEN_W      = 16;
    localparam int ALIGN_W    = 5;
    localparam int BITS_W     = LEN_W + 1 + 3;
    localparam int NS_W       = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 37;
    localparam int DIV_CNT_W  = $clog2(TIME_W);

    localparam logic [NS_W-1:0] NS_PER_SEC = NS_W'(1000000000);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 136;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CIR  = 3'd0,
        REG_CBS  = 3'd1,
        REG_LINK = 3'd2,
        REG_OH   = 3'd3,
        REG_PD   = 3'd4
    } cfg_reg_t;

    // round up to the next 32 ns boundary, wrapping
    function automatic logic [TIME_W-1:0] up32(input logic [TIME_W-1:0] v);
        logic [TIME_W-1:0] s;
        s = v + TIME_W'(31);
        return {s[TIME_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ats_div.sv =====
// ----------------------------------------------------------------------------
// ATS radix-2 divider
// Restoring divider, one quotient bit per cycle; a zero divisor gives all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_div
    import ats_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [TIME_W-1:0] num,
    input  wire logic [RATE_W-1:0] den,
    output logic                   done,
    output logic [TIME_W-1:0]      quo
);

    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    den_reg;
    logic [TIME_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [RATE_W:0]      trial;
    logic                 ge;
    logic [RATE_W:0]      diff;
    logic [RATE_W-1:0]    rem_next;

    assign trial    = {rem_reg, quo_reg[TIME_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};
    assign rem_next = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            den_reg <= den;
            quo_reg <= num;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[TIME_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ats_eligibility_time_shaper_unit.sv =====
// ----------------------------------------------------------------------------
// ATS eligibility time shaper
// Token bucket eligibility time for one flow, on one shared radix-2 divider.
// ----------------------------------------------------------------------------
// Usage: a beat on the s_ side carries the current time and the frame length;
// one beat per frame comes out on the m_ side with the eligible time, the
// assigned (launch) time and the late-arrival flag.
// Sequence: the idle state takes the beat, then come the multiply state, two
// runs of the divider (committed rate, then link rate) and the 64-bit
// add/compare states FIN1 to FIN3. A new frame is taken only once the last
// is through; s_tready is low meanwhile.
// The burst fill time is divided out once after reset-free writes of
// committed_rate or burst_size, in FILL_MUL and FILL_DIV; s_tready is low meanwhile.
// Config: cfg_wr_en/cfg_index/cfg_wdata, written only while idle (by the user;
// not enforced). Rate or burst register writes clear the bucket and link slot times.
// Reset: registers take their defaults, bucket and slot times are zero; no
// precompute is needed at reset as the default burst is zero.
// Stall: the result sits in the output register; the next frame is taken
// but waits in its last step until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_eligibility_time_shaper_unit
    import ats_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // current_time, frame_length
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // eligible_time, assigned_time,
                                                  // late_arrival, zero pad
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_FILL_MUL = 9'b000000010,
        ST_FILL_DIV = 9'b000000100,
        ST_MUL      = 9'b000001000,
        ST_DIV_CIR  = 9'b000010000,
        ST_DIV_LINK = 9'b000100000,
        ST_FIN1     = 9'b001000000,
        ST_FIN2     = 9'b010000000,
        ST_FIN3     = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [RATE_W-1:0]  cir_reg;
    logic [BURST_W-1:0] cbs_reg;
    logic [RATE_W-1:0]  link_reg;
    logic [OH_W-1:0]    oh_reg;
    logic [PD_W-1:0]    pd_reg;

    logic [TIME_W-1:0]  bucket_reg;
    logic [TIME_W-1:0]  slot_reg;
    logic [TIME_W-1:0]  fill_reg;
    logic               dirty_reg;

    logic [TIME_W-1:0]  now_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [TIME_W-1:0]  num_reg;
    logic [TIME_W-1:0]  recover_reg;
    logic [TIME_W-1:0]  linkq_reg;
    logic [TIME_W-1:0]  arrival_reg;
    logic [TIME_W-1:0]  sched_reg;
    logic [TIME_W-1:0]  full_reg;
    logic [TIME_W-1:0]  elig_reg;
    logic [TIME_W-1:0]  diff_reg;
    logic               late_reg;
    logic               start_reg;

    logic [TIME_W-1:0]  out_elig_reg;
    logic [TIME_W-1:0]  out_asg_reg;
    logic               out_late_reg;
    logic               out_valid_reg;

    logic               div_done;
    logic [TIME_W-1:0]  div_quo;
    logic [RATE_W-1:0]  div_den;

    logic               in_fire;
    logic               out_free;
    logic               flow_wr;
    logic [BITS_W-1:0]  bits;
    logic [TIME_W-1:0]  pick;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign flow_wr  = cfg_wr_en && (cfg_index == REG_CIR || cfg_index == REG_CBS);
    assign s_tready = (state_reg == ST_IDLE) && !dirty_reg;
    assign div_den  = (state_reg == ST_DIV_LINK) ? link_reg : cir_reg;
    assign bits     = {(BITS_W-3)'({1'b0, len_reg} + {{(LEN_W-OH_W+1){1'b0}}, oh_reg}), 3'b000};
    assign pick     = (arrival_reg > sched_reg) ? arrival_reg : sched_reg;

    ats_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .num   (num_reg),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // sequencer, config and flow state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cir_reg       <= RATE_W'(1000000000);
            cbs_reg       <= '0;
            link_reg      <= RATE_W'(1000000000);
            oh_reg        <= '0;
            pd_reg        <= '0;
            bucket_reg    <= '0;
            slot_reg      <= '0;
            fill_reg      <= '0;
            dirty_reg     <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (dirty_reg)
                    begin
                        state_reg <= ST_FILL_MUL;
                        dirty_reg <= 1'b0;
                    end
                    else if (in_fire)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_FILL_MUL:
                begin
                    state_reg <= ST_FILL_DIV;
                    start_reg <= 1'b1;
                end
                ST_FILL_DIV:
                begin
                    if (div_done && !start_reg)
                    begin
                        fill_reg  <= div_quo;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV_CIR;
                    start_reg <= 1'b1;
                end
                ST_DIV_CIR:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DIV_LINK;
                        start_reg <= 1'b1;
                    end
                end
                ST_DIV_LINK:
                begin
                    if (div_done && !start_reg)
                    begin
                        state_reg <= ST_FIN1;
                    end
                end
                ST_FIN1:
                begin
                    state_reg <= ST_FIN2;
                end
                ST_FIN2:
                begin
                    slot_reg  <= arrival_reg + up32(linkq_reg);
                    state_reg <= ST_FIN3;
                end
                ST_FIN3:
                begin
                    if (out_free)
                    begin
                        bucket_reg    <= (elig_reg < full_reg) ? sched_reg
                                                               : diff_reg + elig_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // a fill precompute in flight is dropped and rerun
            if (flow_wr && (state_reg == ST_FILL_MUL || state_reg == ST_FILL_DIV))
            begin
                state_reg <= ST_IDLE;
                start_reg <= 1'b0;
            end

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_CIR:
                    begin
                        cir_reg    <= cfg_wdata;
                        bucket_reg <= '0;
                        slot_reg   <= '0;
                        dirty_reg  <= 1'b1;
                    end
                    REG_CBS:
                    begin
                        cbs_reg    <= cfg_wdata[BURST_W-1:0];
                        bucket_reg <= '0;
                        slot_reg   <= '0;
                        dirty_reg  <= 1'b1;
                    end
                    REG_LINK:
                    begin
                        link_reg   <= cfg_wdata;
                        bucket_reg <= '0;
                        slot_reg   <= '0;
                    end
                    REG_OH:
                    begin
                        oh_reg <= cfg_wdata[OH_W-1:0];
                    end
                    REG_PD:
                    begin
                        pd_reg <= {cfg_wdata[PD_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            now_reg <= s_tdata[TIME_W-1:0];
            len_reg <= s_tdata[TIME_W +: LEN_W];
        end
        if (state_reg == ST_FILL_MUL)
        begin
            num_reg <= TIME_W'(cbs_reg * NS_PER_SEC);
        end
        if (state_reg == ST_MUL)
        begin
            num_reg <= TIME_W'(bits * NS_PER_SEC);
        end
        if (state_reg == ST_DIV_CIR && div_done)
        begin
            recover_reg <= div_quo;
        end
        if (state_reg == ST_DIV_LINK && div_done && !start_reg)
        begin
            linkq_reg <= div_quo;
        end
        if (state_reg == ST_FIN1)
        begin
            arrival_reg <= (now_reg > slot_reg) ? now_reg : slot_reg;
            sched_reg   <= bucket_reg + recover_reg;
            full_reg    <= bucket_reg + fill_reg;
        end
        if (state_reg == ST_FIN2)
        begin
            elig_reg <= up32(pick);
            late_reg <= (arrival_reg > sched_reg) && (bucket_reg != '0);
            diff_reg <= sched_reg - full_reg;
        end
        if (state_reg == ST_FIN3 && out_free)
        begin
            out_elig_reg <= elig_reg;
            out_asg_reg  <= elig_reg + {{(TIME_W-PD_W){1'b0}}, pd_reg};
            out_late_reg <= late_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-2*TIME_W-1){1'b0}}, out_late_reg, out_asg_reg, out_elig_reg};

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ATS eligibility time shaper testbench
// A queue-fed driver offers frame beats to the shaper while a monitor takes
// its results. Each accepted frame is run through a local token-bucket model,
// and the monitor compares every result beat field by field with the oldest
// prediction. The run steps through several register settings, including
// the rate extremes, zero rates and out-of-range register writes. It also
// varies the idling on both sides and holds the receiver off for a long
// stretch.
// ----------------------------------------------------------------------------

module tb;
    import ats_pkg::*;

    localparam logic [63:0] NS_IN_SEC    = 64'd1000000000;
    localparam logic [63:0] RATE_MASK    = 64'h1F_FFFF_FFFF;
    localparam int          LIMIT_CYCLES = 1000000;
    localparam int          HOLD_CYCLES  = 3000;
    localparam int          TAIL_CYCLES  = 300;
    localparam int          PAUSE_CYCLES = 150;

    typedef struct {
        logic [63:0] now;
        logic [15:0] len;
    } frame_t;

    typedef struct {
        logic [63:0] elig;
        logic [63:0] launch;
        logic        late;
    } slot_grant_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // current_time, frame_length
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // eligible_time, assigned_time,
                                            // late_arrival, zero pad
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // shaper model state
    logic [63:0] cir_r, cbs_r, link_r, oh_r, pd_r;
    logic [63:0] bucket_at, slot_at;

    frame_t      frame_q[$];
    slot_grant_t grant_q[$];
    frame_t      on_bus;
    logic [63:0] clock_ns;

    int send_idle = 26;
    int recv_idle = 52;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int errors = 0;
    int n_frames = 0;
    int n_grants = 0;
    int n_late = 0;
    int n_writes = 0;
    int cycles = 0;

    ats_eligibility_time_shaper_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] div_or_ones(input logic [63:0] num, input logic [63:0] den);
        if (den == 64'd0)
            return '1;
        return num / den;
    endfunction

    function automatic logic [63:0] ceil32(input logic [63:0] v);
        logic [63:0] s;
        s = v + 64'd31;
        return s & ~64'd31;
    endfunction

    function automatic slot_grant_t shape_frame(input frame_t f);
        logic [63:0] arrival, bits, recover, fill, sched, full, elig;
        slot_grant_t g;
        arrival = (f.now > slot_at) ? f.now : slot_at;
        bits    = (64'(f.len) + oh_r) * 64'd8;
        recover = div_or_ones(bits * NS_IN_SEC, cir_r);
        fill    = div_or_ones(cbs_r * NS_IN_SEC, cir_r);
        sched   = bucket_at + recover;
        full    = bucket_at + fill;
        elig    = ceil32((arrival > sched) ? arrival : sched);
        g.late  = (arrival > sched) && (bucket_at != 64'd0);
        if (elig < full)
            bucket_at = sched;
        else
            bucket_at = sched + elig - full;
        slot_at  = arrival + ceil32(div_or_ones(bits * NS_IN_SEC, link_r));
        g.elig   = elig;
        g.launch = elig + pd_r;
        return g;
    endfunction

    task automatic wait_idle();
        while (!(frame_q.size() == 0 && !s_tvalid && grant_q.size() == 0))
            @(negedge clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        repeat (PAUSE_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CIR:  begin cir_r = 64'(val) & RATE_MASK; bucket_at = '0; slot_at = '0; end
            REG_CBS:  begin cbs_r = 64'(val[31:0]); bucket_at = '0; slot_at = '0; end
            REG_LINK: begin link_r = 64'(val) & RATE_MASK; bucket_at = '0; slot_at = '0; end
            REG_OH:   oh_r = 64'(val[7:0]);
            REG_PD:   pd_r = {32'd0, val[31:ALIGN_W], {ALIGN_W{1'b0}}};
            default:  ;
        endcase
        n_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_shaper(input logic [CFG_DATA_W-1:0] cir, input logic [CFG_DATA_W-1:0] cbs,
                              input logic [CFG_DATA_W-1:0] link, input logic [CFG_DATA_W-1:0] oh,
                              input logic [CFG_DATA_W-1:0] pd);
        program_reg(REG_CIR, cir);
        program_reg(REG_CBS, cbs);
        program_reg(REG_LINK, link);
        program_reg(REG_OH, oh);
        program_reg(REG_PD, pd);
    endtask

    task automatic push_frame(input logic [63:0] now, input logic [15:0] len);
        frame_t f;
        f.now = now;
        f.len = len;
        frame_q.push_back(f);
    endtask

    // mostly a well-formed flow with rising time, some replays and stray times
    task automatic queue_traffic(input int n);
        logic [63:0] bits, span, gap, lk;
        logic [15:0] len;
        int r;
        case ($urandom_range(2))
            0:       clock_ns = '0;
            1:       clock_ns = {$urandom, $urandom};
            default: clock_ns = '1 - 64'($urandom);
        endcase
        for (int i = 0; i < n; i++) begin
            len  = ($urandom_range(99) < 85) ? 16'($urandom_range(64, 1518)) : 16'($urandom);
            bits = (64'(len) + oh_r) * 64'd8;
            span = div_or_ones(bits * NS_IN_SEC, cir_r);
            lk   = div_or_ones(bits * NS_IN_SEC, link_r);
            if (lk > span)
                span = lk;
            if (span > (64'd1 << 40))
                span = 64'd1 << 40;
            r = $urandom_range(99);
            if (r < 10) begin
                push_frame(clock_ns, len);
            end
            else if (r < 80) begin
                gap = {$urandom, $urandom} % (span * 64'd2 + 64'd64);
                clock_ns = clock_ns + gap;
                push_frame(clock_ns, len);
            end
            else if (r < 90) begin
                push_frame(clock_ns - ({$urandom, $urandom} % (span + 64'd64)), len);
            end
            else begin
                push_frame({$urandom, $urandom}, 16'($urandom));
            end
        end
    endtask

    // frame driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                grant_q.push_back(shape_frame(on_bus));
                n_frames++;
            end
            if (!s_tvalid || s_tready) begin
                if (frame_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    on_bus = frame_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {on_bus.len, on_bus.now};
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk) begin : monitor
        slot_grant_t want;
        logic [63:0] got_elig, got_launch;
        logic        got_late;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got_elig   = m_tdata[63:0];
                got_launch = m_tdata[127:64];
                got_late   = m_tdata[128];
                n_grants++;
                if (got_late)
                    n_late++;
                if (grant_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual elig %h", $time,
                             got_elig);
                end
                else begin
                    want = grant_q.pop_front();
                    if (got_elig !== want.elig) begin
                        errors++;
                        $display("%0t: eligible_time expected %h actual %h", $time,
                                 want.elig, got_elig);
                    end
                    if (got_launch !== want.launch) begin
                        errors++;
                        $display("%0t: assigned_time expected %h actual %h", $time,
                                 want.launch, got_launch);
                    end
                    if (got_late !== want.late) begin
                        errors++;
                        $display("%0t: late_arrival expected %b actual %b", $time,
                                 want.late, got_late);
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results outstanding", $time, grant_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        cir_r     = 64'd1000000000;
        cbs_r     = '0;
        link_r    = 64'd1000000000;
        oh_r      = '0;
        pd_r      = '0;
        bucket_at = '0;
        slot_at   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: length and time extremes, back-to-back, wrap
        push_frame(64'd0, 16'd0);
        push_frame(64'd0, 16'd1);
        push_frame(64'd0, 16'hFFFF);
        for (int i = 0; i < 4; i++)
            push_frame(64'd1000, 16'd1500);
        push_frame(64'd1000000, 16'd64);
        push_frame(64'd1000001, 16'hAAAA);
        push_frame(64'h5555_5555_5555_5555, 16'h5555);
        push_frame(64'hAAAA_AAAA_AAAA_AAAA, 16'h00FF);
        push_frame(64'hFFFF_FFFF_FFFF_FFE0, 16'd1500);
        push_frame('1, 16'hFFFF);
        push_frame('1, 16'd0);
        push_frame(64'd0, 16'd64);
        push_frame(64'h8000_0000_0000_0000, 16'h8000);
        push_frame(64'd31, 16'd1);
        push_frame(64'd33, 16'd1);

        // typical flow, unaligned processing delay
        set_shaper(37'd100000000, 37'd12000, 37'd1000000000, 37'd20, 37'd1000);
        queue_traffic(250);

        // top of every range, upper write bits set on narrow registers
        set_shaper('1, '1, '1, '1, '1);
        queue_traffic(200);

        // slowest non-zero rates
        set_shaper(37'd1, 37'd0, 37'd1, 37'd0, 37'd0);
        queue_traffic(150);

        send_idle = 52;
        recv_idle = 26;
        // zero rates, then writes to unused indexes
        set_shaper(37'd0, 37'($urandom), 37'd0, 37'($urandom_range(255)), 37'($urandom));
        for (int k = int'(REG_PD) + 1; k < (1 << CFG_IDX_W); k++)
            program_reg(CFG_IDX_W'(k), CFG_DATA_W'({$urandom, $urandom}));
        queue_traffic(150);

        set_shaper(37'd10000000, 37'd50000, 37'd100000000, 37'd24, 37'd31);
        queue_traffic(250);

        set_shaper(37'($urandom_range(1000, 2000000000)), 37'($urandom),
                   37'(64'($urandom_range(1000, 2000000000)) * $urandom_range(1, 50)),
                   37'($urandom_range(255)), 37'($urandom));
        queue_traffic(200);

        send_idle = 0;
        recv_idle = 0;
        set_shaper(37'd1000000000, 37'd1000000, 37'd10000000000, 37'd38, 37'd5000);
        hold_arm = 1'b1;
        queue_traffic(250);

        // overhead and delay only: bucket state carries over
        program_reg(REG_OH, 37'($urandom_range(255)));
        program_reg(REG_PD, 37'($urandom));
        queue_traffic(150);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d frames, %0d results (%0d late) across %0d register writes,",
                 n_frames, n_grants, n_late, n_writes);
        $display("with rate extremes, zero rates, unused indexes and a long output stall.");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
